### design/audio_presence_amp_auto_off_core_defines.svh
// ============================================================================
// audio presence amp auto-off assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ============================================================================
`ifndef AUDIO_PRESENCE_AMP_AUTO_OFF_CORE_DEFINES_SVH
`define AUDIO_PRESENCE_AMP_AUTO_OFF_CORE_DEFINES_SVH

// same-cycle implication
`define APC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/apc_pkg.sv
// ============================================================================
// apc_pkg
// Types, codes and constants shared by the amplifier auto-off controller.
// ============================================================================
`default_nettype none

package apc_pkg;

    // item opcodes
    typedef enum logic [2:0] {
        OP_SAMPLE = 3'd0,
        OP_TICK   = 3'd1,
        OP_ON     = 3'd2,
        OP_OFF    = 3'd3,
        OP_ARM    = 3'd4
    } op_t;

    // power modes, code 3 takes no mode action
    typedef enum logic [1:0] {
        MODE_ON   = 2'd0,
        MODE_OFF  = 2'd1,
        MODE_AUTO = 2'd2
    } mode_t;

    // register indexes
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_ALPHA     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_HOLD      = 2'd3;

    // reset values and fixed constants
    localparam logic [15:0]        ALPHA_RESET     = 16'd9830;
    localparam logic signed [15:0] THRESHOLD_RESET = -16'sd15360;
    localparam logic [5:0]         HOLD_RESET      = 6'd15;
    localparam logic signed [15:0] LEVEL_FLOOR     = -16'sd24576;
    localparam logic [9:0]         STEP_MS         = 10'd1000;
    localparam logic [11:0]        SECS_PER_MIN    = 12'd60;
    localparam logic [5:0]         HOLD_MIN        = 6'd1;
    localparam logic [5:0]         HOLD_MAX        = 6'd60;

    typedef struct packed {
        mode_t              mode;
        logic [15:0]        ema_alpha;
        logic signed [15:0] threshold_level;
        logic [11:0]        reload_secs;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] level;
        logic               raw_detect;
    } item_t;

    typedef struct packed {
        logic               amp_on;
        logic [11:0]        seconds_left;
        logic               signal_present;
        logic signed [15:0] smoothed_level;
    } result_t;

endpackage

`default_nettype wire

### design/audio_presence_amp_auto_off_core.sv
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless out_ready stalls; the state loop is
// combinational through the moving-average multiply, add and threshold compare.
// An input register and a result register decouple the two channels.
// Reset (rst_n low, asynchronous) clears valid flags, config and controller state.
// ============================================================================
// audio_presence_amp_auto_off_core
// Amplifier power controller driven by a smoothed audio level.
// ============================================================================
`default_nettype none

module audio_presence_amp_auto_off_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [15:0] level,
    input  wire logic               raw_detect,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    amp_on,
    output logic [11:0]             seconds_left,
    output logic                    signal_present,
    output logic signed [15:0]      smoothed_level
);
    import apc_pkg::*;

    `include "audio_presence_amp_auto_off_core_defines.svh"

    cfg_t               cfg;
    item_t              item;
    result_t            res;
    result_t            result_reg;
    logic [2:0]         opcode_reg;
    logic signed [15:0] level_reg;
    logic               raw_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               adv;
    logic signed [15:0] avg_cur;
    logic signed [15:0] ema_avg;

    // handshake control
    assign adv            = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || adv;
    assign in_valid_next  = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
    assign out_valid_next = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input item register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg <= opcode;
            level_reg  <= level;
            raw_reg    <= raw_detect;
        end
    end

    assign item.op         = op_t'(opcode_reg);
    assign item.level      = level_reg;
    assign item.raw_detect = raw_reg;

    // configuration registers
    apc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // moving-average step
    apc_ema u_ema (
        .level   (level_reg),
        .avg     (avg_cur),
        .alpha   (cfg.ema_alpha),
        .avg_new (ema_avg)
    );

    // controller state
    apc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .item    (item),
        .cfg     (cfg),
        .ema_avg (ema_avg),
        .avg_cur (avg_cur),
        .res     (res)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign amp_on         = result_reg.amp_on;
    assign seconds_left   = result_reg.seconds_left;
    assign signal_present = result_reg.signal_present;
    assign smoothed_level = result_reg.smoothed_level;

    // checks
    `APC_ASSERT_NEXT(a_in_capture, in_valid && in_ready, in_valid_reg, "accepted item not held")
    `APC_ASSERT_NEXT(a_in_keep, in_valid_reg && !adv, in_valid_reg, "waiting item dropped")
    `APC_ASSERT_NEXT(a_out_load, adv, out_valid_reg, "processed item gave no result")
    `APC_ASSERT_NOW(a_secs_range, out_valid_reg, seconds_left <= 12'd3600, "result hold time out of range")

endmodule

`default_nettype wire

### design/apc_cfg.sv
// ============================================================================
// apc_cfg
// Configuration registers and the derived hold reload in seconds.
// ============================================================================
`default_nettype none

module apc_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output apc_pkg::cfg_t      cfg
);
    import apc_pkg::*;

    mode_t              mode_reg;
    logic [15:0]        alpha_reg;
    logic signed [15:0] threshold_reg;
    logic [5:0]         hold_reg;
    logic [5:0]         minutes;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ON;
            alpha_reg     <= ALPHA_RESET;
            threshold_reg <= THRESHOLD_RESET;
            hold_reg      <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:      mode_reg      <= mode_t'(cfg_data[1:0]);
                CFG_ALPHA:     alpha_reg     <= cfg_data;
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_HOLD:      hold_reg      <= cfg_data[5:0];
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    // clamp minutes to 1..60 before scaling
    always_comb
    begin
        minutes = hold_reg;
        if (hold_reg < HOLD_MIN)
            minutes = HOLD_MIN;
        else if (hold_reg > HOLD_MAX)
            minutes = HOLD_MAX;
    end

    assign cfg.mode            = mode_reg;
    assign cfg.ema_alpha       = alpha_reg;
    assign cfg.threshold_level = threshold_reg;
    assign cfg.reload_secs     = 12'(minutes) * SECS_PER_MIN;

endmodule

`default_nettype wire

### design/apc_ema.sv
// ============================================================================
// apc_ema
// One moving-average step: avg + round_half_up((level - avg) * alpha / 2^16).
// ============================================================================
`default_nettype none

module apc_ema (
    input  wire logic signed [15:0] level,
    input  wire logic signed [15:0] avg,
    input  wire logic [15:0]        alpha,
    output logic signed [15:0]      avg_new
);
    logic signed [16:0] diff;
    logic signed [16:0] alpha_s;
    logic signed [33:0] prod;
    logic signed [33:0] rounded;
    logic signed [17:0] step;
    logic signed [17:0] sum;

    // difference and weighted product
    assign diff    = 17'(level) - 17'(avg);
    assign alpha_s = signed'({1'b0, alpha});
    assign prod    = 34'(diff) * 34'(alpha_s);

    // round half up, floor shift keeps the sign
    assign rounded = prod + 34'sd32768;
    assign step    = rounded[33:16];
    assign sum     = 18'(avg) + step;
    assign avg_new = sum[15:0];

endmodule

`default_nettype wire

### design/apc_ctrl.sv
// ============================================================================
// apc_ctrl
// Controller state and its next-state logic for one item.
// ============================================================================
`default_nettype none

module apc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire apc_pkg::item_t     item,
    input  wire apc_pkg::cfg_t      cfg,
    input  wire logic signed [15:0] ema_avg,
    output logic signed [15:0]      avg_cur,
    output apc_pkg::result_t        res
);
    import apc_pkg::*;

    `include "audio_presence_amp_auto_off_core_defines.svh"

    logic signed [15:0] avg_reg;
    logic signed [15:0] avg_next;
    logic               amp_reg;
    logic               amp_next;
    logic [11:0]        hs_reg;
    logic [11:0]        hs_next;
    logic [9:0]         ms_reg;
    logic [9:0]         ms_next;
    logic               run_mode;
    logic               pres;

    // item action, then mode action on sample and tick
    always_comb
    begin
        avg_next = avg_reg;
        amp_next = amp_reg;
        hs_next  = hs_reg;
        ms_next  = ms_reg;
        run_mode = 1'b0;
        case (item.op)
            OP_SAMPLE:
            begin
                avg_next = ema_avg;
                run_mode = 1'b1;
            end
            OP_TICK:
            begin
                if (ms_reg < STEP_MS)
                    ms_next = ms_reg + 10'd1;
                run_mode = 1'b1;
            end
            OP_ON:
            begin
                amp_next = 1'b1;
                if (cfg.mode == MODE_AUTO)
                begin
                    hs_next = cfg.reload_secs;
                    ms_next = '0;
                end
            end
            OP_OFF:
            begin
                amp_next = 1'b0;
                if (cfg.mode == MODE_AUTO)
                    hs_next = '0;
            end
            OP_ARM:
            begin
                if (cfg.mode == MODE_AUTO)
                begin
                    avg_next = item.level;
                    if (item.raw_detect)
                    begin
                        hs_next  = cfg.reload_secs;
                        ms_next  = '0;
                        amp_next = 1'b1;
                    end
                    else
                    begin
                        hs_next  = '0;
                        amp_next = 1'b0;
                    end
                end
            end
            default:
            begin
                run_mode = 1'b0;
            end
        endcase

        pres = (avg_next >= cfg.threshold_level);

        if (run_mode)
        begin
            case (cfg.mode)
                MODE_ON:
                begin
                    amp_next = 1'b1;
                    hs_next  = '0;
                end
                MODE_OFF:
                begin
                    amp_next = 1'b0;
                    hs_next  = '0;
                end
                MODE_AUTO:
                begin
                    if (pres)
                    begin
                        hs_next  = cfg.reload_secs;
                        ms_next  = '0;
                        amp_next = 1'b1;
                    end
                    else if (amp_next && hs_next != 12'd0 && ms_next >= STEP_MS)
                    begin
                        ms_next = '0;
                        hs_next = hs_next - 12'd1;
                        if (hs_next == 12'd0)
                            amp_next = 1'b0;
                    end
                end
                default:
                begin
                    amp_next = amp_next;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= LEVEL_FLOOR;
            amp_reg <= 1'b0;
            hs_reg  <= '0;
            ms_reg  <= '0;
        end
        else if (adv)
        begin
            avg_reg <= avg_next;
            amp_reg <= amp_next;
            hs_reg  <= hs_next;
            ms_reg  <= ms_next;
        end
    end

    assign avg_cur            = avg_reg;
    assign res.amp_on         = amp_next;
    assign res.seconds_left   = hs_next;
    assign res.signal_present = pres;
    assign res.smoothed_level = avg_next;

    // checks
    `APC_ASSERT_NOW(a_ms_sat, 1'b1, ms_reg <= STEP_MS, "tick counter past saturation")
    `APC_ASSERT_NOW(a_hs_range, 1'b1, hs_reg <= 12'd3600, "hold timer beyond one hour")
    `APC_ASSERT_NEXT(a_present_on,
        adv && item.op == OP_SAMPLE && cfg.mode == MODE_AUTO && pres,
        amp_reg && hs_reg == $past(cfg.reload_secs), "presence did not reload and enable")

endmodule

`default_nettype wire
